>>> rtl/core/dense_layer_relu_forward_defines.svh
// Assertion macros for the dense layer block.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef DENSE_LAYER_RELU_FORWARD_DEFINES_SVH
`define DENSE_LAYER_RELU_FORWARD_DEFINES_SVH
`ifndef ASSERT_OFF
// Holds at every edge out of reset.
`define FCLR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// A condition that must never be seen.
`define FCLR_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define FCLR_ASSERT(label, prop, msg)
`define FCLR_NEVER(label, cond, msg)
`endif
`endif

>>> rtl/core/fclr_pkg.sv
// Shared types and constants of the dense layer block.
// Depends on nothing.
package fclr_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 8;
	localparam int CFG_WIDTH  = 7;
	localparam int DATA_MAX   = 2 ** (DATA_WIDTH - 1) - 1;
	localparam int DATA_MIN   = -(2 ** (DATA_WIDTH - 1));

	localparam logic [1:0] KIND_WEIGHT = 2'd0;
	localparam logic [1:0] KIND_BIAS   = 2'd1;
	localparam logic [1:0] KIND_ACT    = 2'd2;

	localparam logic [1:0] CFG_IN_COUNT  = 2'd0;
	localparam logic [1:0] CFG_OUT_COUNT = 2'd1;
	localparam logic [1:0] CFG_RELU      = 2'd2;

	typedef struct packed {
		logic [1:0]                   kind;
		logic [5:0]                   out_index;
		logic [5:0]                   in_index;
		logic signed [DATA_WIDTH-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [5:0]                   feature_index;
		logic signed [DATA_WIDTH-1:0] activation_out;
		logic                         last;
	} out_item_t;

	// store strobes from the sequencer
	typedef struct packed {
		logic w_we;
		logic b_we;
		logic x_we;
		logic rd_en;
	} mem_ctl_t;

	// tags that travel alongside each multiply-accumulate
	typedef struct packed {
		logic       valid;
		logic       first;
		logic       last_in;
		logic       last_out;
		logic [5:0] feature;
	} mac_ctl_t;

endpackage

>>> rtl/core/fclr_store.sv
// Weight, bias and row memories, single port, registered read.
// Depends on fclr_pkg.
module fclr_store #(
	parameter int OW = 6,
	parameter int IW = 6
) (
	input  logic                                   clk,
	input  fclr_pkg::mem_ctl_t                     mem_ctl,
	input  logic [OW-1:0]                          addr_o,
	input  logic [IW-1:0]                          addr_i,
	input  logic signed [fclr_pkg::DATA_WIDTH-1:0] wdata,
	output logic signed [fclr_pkg::DATA_WIDTH-1:0] w_rdata,
	output logic signed [fclr_pkg::DATA_WIDTH-1:0] b_rdata,
	output logic signed [fclr_pkg::DATA_WIDTH-1:0] x_rdata
);
	import fclr_pkg::*;

	localparam int W_DEPTH = 2 ** (OW + IW);
	localparam int B_DEPTH = 2 ** OW;
	localparam int X_DEPTH = 2 ** IW;

	logic signed [DATA_WIDTH-1:0] weight_mem [W_DEPTH];
	logic signed [DATA_WIDTH-1:0] bias_mem   [B_DEPTH];
	logic signed [DATA_WIDTH-1:0] row_mem    [X_DEPTH];

	always_ff @(posedge clk) begin
		if (mem_ctl.w_we) begin
			weight_mem[{addr_o, addr_i}] <= wdata;
		end
		if (mem_ctl.rd_en) begin
			w_rdata <= weight_mem[{addr_o, addr_i}];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_ctl.b_we) begin
			bias_mem[addr_o] <= wdata;
		end
		if (mem_ctl.rd_en) begin
			b_rdata <= bias_mem[addr_o];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_ctl.x_we) begin
			row_mem[addr_i] <= wdata;
		end
		if (mem_ctl.rd_en) begin
			x_rdata <= row_mem[addr_i];
		end
	end

endmodule

>>> rtl/core/fclr_seq.sv
// Configuration registers, item decode and the row/column read sequencer.
// Depends on fclr_pkg.
module fclr_seq #(
	parameter int IN_MAX  = 64,
	parameter int OUT_MAX = 64,
	parameter int OW      = 6,
	parameter int IW      = 6
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  fclr_pkg::in_item_t               command,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [fclr_pkg::CFG_WIDTH-1:0]   cfg_data,
	output fclr_pkg::mem_ctl_t               mem_ctl,
	output logic [OW-1:0]                    addr_o,
	output logic [IW-1:0]                    addr_i,
	output fclr_pkg::mac_ctl_t               ctl,
	output logic                             relu_enable,
	output logic                             trigger
);
	import fclr_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t               state_q;
	logic [OW-1:0]        o_q;
	logic [IW-1:0]        i_q;
	logic [CFG_WIDTH-1:0] in_count_q;
	logic [CFG_WIDTH-1:0] out_count_q;
	logic                 relu_q;
	logic [IW-1:0]        n_in_m1;
	logic [OW-1:0]        n_out_m1;
	logic                 accept;
	logic                 in_ok;
	logic                 out_ok;
	logic                 running;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_count_q  <= CFG_WIDTH'(64);
			out_count_q <= CFG_WIDTH'(64);
			relu_q      <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IN_COUNT:  in_count_q  <= cfg_data;
				CFG_OUT_COUNT: out_count_q <= cfg_data;
				CFG_RELU:      relu_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// saturate the counts into 1..max
	always_comb begin
		if (in_count_q == '0) begin
			n_in_m1 = '0;
		end else if (32'(in_count_q) > IN_MAX) begin
			n_in_m1 = IW'(IN_MAX - 1);
		end else begin
			n_in_m1 = IW'(in_count_q - CFG_WIDTH'(1));
		end
		if (out_count_q == '0) begin
			n_out_m1 = '0;
		end else if (32'(out_count_q) > OUT_MAX) begin
			n_out_m1 = OW'(OUT_MAX - 1);
		end else begin
			n_out_m1 = OW'(out_count_q - CFG_WIDTH'(1));
		end
	end

	assign running = (state_q == ST_RUN);
	assign busy    = running;
	assign accept  = start && !running;
	assign in_ok   = 32'(command.in_index) < IN_MAX;
	assign out_ok  = 32'(command.out_index) < OUT_MAX;
	assign trigger = accept && command.kind == KIND_ACT && in_ok
		&& IW'(command.in_index) == n_in_m1;

	always_comb begin
		mem_ctl.w_we  = accept && command.kind == KIND_WEIGHT && in_ok && out_ok;
		mem_ctl.b_we  = accept && command.kind == KIND_BIAS && out_ok;
		mem_ctl.x_we  = accept && command.kind == KIND_ACT && in_ok;
		mem_ctl.rd_en = running;
	end

	assign addr_o = running ? o_q : OW'(command.out_index);
	assign addr_i = running ? i_q : IW'(command.in_index);

	always_comb begin
		ctl.valid    = running;
		ctl.first    = (i_q == '0);
		ctl.last_in  = (i_q == n_in_m1);
		ctl.last_out = (o_q == n_out_m1);
		ctl.feature  = 6'(o_q);
	end

	assign relu_enable = relu_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			o_q     <= '0;
			i_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (trigger) begin
						state_q <= ST_RUN;
						o_q     <= '0;
						i_q     <= '0;
					end
				end
				ST_RUN: begin
					if (i_q == n_in_m1) begin
						i_q <= '0;
						if (o_q == n_out_m1) begin
							state_q <= ST_IDLE;
						end else begin
							o_q <= o_q + 1'b1;
						end
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/fclr_mac.sv
// Multiply-accumulate pipeline with bias, ReLU and saturation.
// Depends on fclr_pkg; fed by fclr_store read data and fclr_seq tags.
module fclr_mac #(
	parameter int IW = 6
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  fclr_pkg::mac_ctl_t                     ctl,
	input  logic                                   relu_enable,
	input  logic signed [fclr_pkg::DATA_WIDTH-1:0] w_rdata,
	input  logic signed [fclr_pkg::DATA_WIDTH-1:0] b_rdata,
	input  logic signed [fclr_pkg::DATA_WIDTH-1:0] x_rdata,
	output fclr_pkg::out_item_t                    result,
	output logic                                   result_strobe
);
	import fclr_pkg::*;

	localparam int PROD_W = 2 * DATA_WIDTH;
	localparam int ACC_W  = PROD_W + IW;
	localparam int SUM_W  = ACC_W - FRAC_BITS + 1;

	mac_ctl_t                     ctl_s1;
	mac_ctl_t                     ctl_s2;
	logic signed [PROD_W-1:0]     prod_s2;
	logic signed [DATA_WIDTH-1:0] bias_s2;
	logic signed [ACC_W-1:0]      acc_q;
	logic signed [DATA_WIDTH-1:0] bias_s3;
	logic                         fin_valid_s3;
	logic                         fin_last_s3;
	logic [5:0]                   fin_feature_s3;
	logic signed [ACC_W-1:0]      shifted;
	logic signed [SUM_W-1:0]      sum;
	logic signed [DATA_WIDTH-1:0] sat;
	out_item_t                    result_q;
	logic                         strobe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1       <= '0;
			ctl_s2       <= '0;
			fin_valid_s3 <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			ctl_s1       <= ctl;
			ctl_s2       <= ctl_s1;
			fin_valid_s3 <= ctl_s2.valid && ctl_s2.last_in;
			strobe_q     <= fin_valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= w_rdata * x_rdata;
		bias_s2 <= b_rdata;
		if (ctl_s2.valid) begin
			acc_q <= (ctl_s2.first ? '0 : acc_q) + ACC_W'(prod_s2);
		end
		if (ctl_s2.valid && ctl_s2.last_in) begin
			bias_s3        <= bias_s2;
			fin_last_s3    <= ctl_s2.last_out;
			fin_feature_s3 <= ctl_s2.feature;
		end
	end

	// floor shift, add bias, apply ReLU when enabled, then clip to the output range
	always_comb begin
		shifted = acc_q >>> FRAC_BITS;
		sum     = SUM_W'(shifted) + SUM_W'(bias_s3);
		if (relu_enable && sum < 0) begin
			sat = '0;
		end else if (sum > SUM_W'(DATA_MAX)) begin
			sat = DATA_WIDTH'(DATA_MAX);
		end else if (sum < SUM_W'(DATA_MIN)) begin
			sat = DATA_WIDTH'(DATA_MIN);
		end else begin
			sat = DATA_WIDTH'(sum);
		end
	end

	always_ff @(posedge clk) begin
		if (fin_valid_s3) begin
			result_q.feature_index  <= fin_feature_s3;
			result_q.activation_out <= sat;
			result_q.last           <= fin_last_s3;
		end
	end

	assign result        = result_q;
	assign result_strobe = strobe_q;

endmodule

>>> rtl/core/dense_layer_relu_forward.sv
// Fully connected layer with ReLU; one multiply-accumulate a cycle out of the weight memory port.
// A completing activation item keeps busy high for the whole sweep, then the next item is taken.
// Results pass the read, product, accumulator and result registers; other items leave busy low.
// Results arrive one per output row and cannot be held off by the receiver.
// Reset clears control and configuration (in_count 64, out_count 64, ReLU on); memories keep data.
`include "dense_layer_relu_forward_defines.svh"
module dense_layer_relu_forward #(
	parameter int IN_MAX  = 64,
	parameter int OUT_MAX = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  fclr_pkg::in_item_t             command,
	output fclr_pkg::out_item_t            result,
	output logic                           result_strobe,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [fclr_pkg::CFG_WIDTH-1:0] cfg_data
);
	import fclr_pkg::*;

	localparam int IW = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
	localparam int OW = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;

	mem_ctl_t                     mem_ctl;
	mac_ctl_t                     ctl;
	logic [OW-1:0]                addr_o;
	logic [IW-1:0]                addr_i;
	logic signed [DATA_WIDTH-1:0] w_rdata;
	logic signed [DATA_WIDTH-1:0] b_rdata;
	logic signed [DATA_WIDTH-1:0] x_rdata;
	logic                         relu_enable;
	logic                         trigger;

	fclr_seq #(
		.IN_MAX (IN_MAX),
		.OUT_MAX(OUT_MAX),
		.OW     (OW),
		.IW     (IW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mem_ctl    (mem_ctl),
		.addr_o     (addr_o),
		.addr_i     (addr_i),
		.ctl        (ctl),
		.relu_enable(relu_enable),
		.trigger    (trigger)
	);

	fclr_store #(
		.OW(OW),
		.IW(IW)
	) u_store (
		.clk    (clk),
		.mem_ctl(mem_ctl),
		.addr_o (addr_o),
		.addr_i (addr_i),
		.wdata  (command.value),
		.w_rdata(w_rdata),
		.b_rdata(b_rdata),
		.x_rdata(x_rdata)
	);

	fclr_mac #(
		.IW(IW)
	) u_mac (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.relu_enable  (relu_enable),
		.w_rdata      (w_rdata),
		.b_rdata      (b_rdata),
		.x_rdata      (x_rdata),
		.result       (result),
		.result_strobe(result_strobe)
	);

	`FCLR_NEVER(a_port_clash, mem_ctl.rd_en && (mem_ctl.w_we || mem_ctl.b_we || mem_ctl.x_we), "memory write during read sweep")
	`FCLR_ASSERT(a_trigger_busy, trigger |=> busy, "row completion did not start the sweep")
	`FCLR_ASSERT(a_busy_end, $fell(busy) |-> $past(ctl.last_in && ctl.last_out), "sweep ended early")
	`FCLR_ASSERT(a_last_gap, (result_strobe && result.last) |=> !result_strobe, "result straight after last")

endmodule
